[src/rbas_pkg.sv]
// rbas_pkg: shared sizes, limits and word types for the rarest byte anchor select block.
// No dependencies; the module files refer to it by scoped names.
package rbas_pkg;

    localparam int MAX_SIG_LEN = 64;
    localparam int SIG_IDX_W   = (MAX_SIG_LEN > 1) ? $clog2(MAX_SIG_LEN) : 1;
    localparam int SIG_CNT_W   = $clog2(MAX_SIG_LEN + 1);

    localparam int BYTE_W      = 8;
    localparam int HIST_DEPTH  = 256;
    localparam int HIST_CNT_W  = 8;
    localparam logic [HIST_CNT_W-1:0] HIST_CNT_MAX = 8'hFF;

    localparam int OUT_IDX_W   = 6;

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [BYTE_W-1:0] byte_value;
        logic              fully_known;
        logic              is_last;
    } t_item;

    // head of the element queue as seen by the back end
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_head;

endpackage

[src/rbas_ifs.sv]
// rbas_in_if / rbas_out_if: valid-ready channels for signature elements and anchor results.
// Depends on nothing; widths follow the field definitions of the block.
interface rbas_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       fully_known;
    logic       is_last;

    modport source (output valid, output byte_value, output fully_known, output is_last,
                    input ready);
    modport sink   (input valid, input byte_value, input fully_known, input is_last,
                    output ready);
endinterface

interface rbas_out_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [5:0] anchor_index;
    logic [7:0] anchor_count;

    modport source (output valid, output found, output anchor_index, output anchor_count,
                    input ready);
    modport sink   (input valid, input found, input anchor_index, input anchor_count,
                    output ready);
endinterface

[src/rbas_front.sv]
// rbas_front: accepts element words and queues them for the back end.
// Depends on rbas_pkg and rbas_in_if.
module rbas_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    rbas_in_if.sink            i_in,
    input  logic               i_pop,
    output rbas_pkg::t_q_head  o_head
);

    rbas_pkg::t_item                       r_mem [rbas_pkg::FIFO_DEPTH];
    logic [rbas_pkg::FIFO_AW-1:0]          r_wr_ptr;
    logic [rbas_pkg::FIFO_AW-1:0]          r_rd_ptr;
    logic [rbas_pkg::FIFO_CNT_W-1:0]       r_count;
    logic                                  push;
    logic                                  pop;
    rbas_pkg::t_item                       in_item;

    assign i_in.ready = (r_count != rbas_pkg::FIFO_CNT_W'(rbas_pkg::FIFO_DEPTH));
    assign push       = i_in.valid && i_in.ready;
    assign pop        = i_pop && (r_count != '0);

    always_comb begin
        in_item.byte_value  = i_in.byte_value;
        in_item.fully_known = i_in.fully_known;
        in_item.is_last     = i_in.is_last;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= rbas_pkg::FIFO_CNT_W'(rbas_pkg::FIFO_DEPTH))
        else $error("element queue overfilled");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> !pop)
        else $error("pop from empty element queue");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not advance on push");

endmodule

[src/rbas_back.sv]
// rbas_back: stores the signature, updates the byte histogram and walks for the rarest byte.
// Depends on rbas_pkg and rbas_out_if; takes elements from the rbas_front queue.
module rbas_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rbas_pkg::t_q_head i_head,
    output logic              o_pop,
    rbas_out_if.source        o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPD,
        S_WALK,
        S_RES
    } t_state;

    localparam int IW = rbas_pkg::SIG_IDX_W;
    localparam int CW = rbas_pkg::SIG_CNT_W;
    localparam int HW = rbas_pkg::HIST_CNT_W;
    localparam int BW = rbas_pkg::BYTE_W;

    t_state                  r_state;
    logic [CW-1:0]           r_elem_cnt;
    logic [BW-1:0]           r_upd_addr;
    logic                    r_upd_last;

    // signature store: {known, byte}
    logic [BW:0]             r_sig_mem [rbas_pkg::MAX_SIG_LEN];
    logic [BW:0]             r_sig_rd;
    logic [HW-1:0]           r_hist_mem [rbas_pkg::HIST_DEPTH];
    logic [HW-1:0]           r_hist_rd;
    logic                    r_hist_rd_vld;
    logic [rbas_pkg::HIST_DEPTH-1:0] r_hvalid;

    logic [CW-1:0]           r_walk_i;
    logic                    r_s1_vld;
    logic [IW-1:0]           r_s1_idx;
    logic                    r_s2_vld;
    logic [IW-1:0]           r_s2_idx;
    logic                    r_s2_known;

    logic                    r_found;
    logic [IW-1:0]           r_best_idx;
    logic [HW-1:0]           r_best_cnt;

    logic                    r_out_valid;
    logic                    r_out_found;
    logic [rbas_pkg::OUT_IDX_W-1:0] r_out_idx;
    logic [HW-1:0]           r_out_cnt;

    logic                    pop;
    logic                    stored;
    logic                    sig_we;
    logic                    hist_we;
    logic [HW-1:0]           hist_cur;
    logic [HW-1:0]           hist_inc;
    logic [BW-1:0]           hist_raddr;
    logic                    issue;
    logic                    walk_done;
    logic [HW-1:0]           walk_cnt;
    logic                    better;
    logic                    res_load;
    logic [IW+rbas_pkg::OUT_IDX_W-1:0] best_idx_ext;

    assign pop      = (r_state == S_IDLE) && i_head.valid;
    assign o_pop    = pop;
    assign stored   = (r_elem_cnt < CW'(rbas_pkg::MAX_SIG_LEN));
    assign sig_we   = pop && stored;

    assign hist_cur = r_hist_rd_vld ? r_hist_rd : '0;
    assign hist_inc = (hist_cur == rbas_pkg::HIST_CNT_MAX) ? hist_cur : hist_cur + 1'b1;
    assign hist_we  = (r_state == S_UPD);

    // walk reads the histogram at the stored byte; loading reads it at the incoming byte
    assign hist_raddr = (r_state == S_WALK) ? r_sig_rd[BW-1:0] : i_head.item.byte_value;

    assign issue     = (r_state == S_WALK) && (r_walk_i < r_elem_cnt);
    assign walk_done = (r_state == S_WALK) && !issue && !r_s1_vld && !r_s2_vld;
    assign walk_cnt  = hist_cur;
    assign better    = r_s2_vld && r_s2_known && (!r_found || (walk_cnt < r_best_cnt));
    assign res_load  = (r_state == S_RES) && (!r_out_valid || o_out.ready);

    assign best_idx_ext = {{rbas_pkg::OUT_IDX_W{1'b0}}, r_best_idx};

    always_ff @(posedge i_clk) begin
        if (sig_we) begin
            r_sig_mem[r_elem_cnt[IW-1:0]] <= {i_head.item.fully_known, i_head.item.byte_value};
        end
        r_sig_rd <= r_sig_mem[r_walk_i[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            r_hist_mem[r_upd_addr] <= hist_inc;
        end
        r_hist_rd <= r_hist_mem[hist_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_elem_cnt    <= '0;
            r_upd_addr    <= '0;
            r_upd_last    <= 1'b0;
            r_hvalid      <= '0;
            r_hist_rd_vld <= 1'b0;
            r_walk_i      <= '0;
            r_s1_vld      <= 1'b0;
            r_s1_idx      <= '0;
            r_s2_vld      <= 1'b0;
            r_s2_idx      <= '0;
            r_s2_known    <= 1'b0;
            r_found       <= 1'b0;
            r_best_idx    <= '0;
            r_best_cnt    <= rbas_pkg::HIST_CNT_MAX;
            r_out_valid   <= 1'b0;
            r_out_found   <= 1'b0;
            r_out_idx     <= '0;
            r_out_cnt     <= '0;
        end else begin
            r_hist_rd_vld <= r_hvalid[hist_raddr];

            // walk pipeline: address, stored word, histogram count
            r_s1_vld   <= issue;
            r_s1_idx   <= r_walk_i[IW-1:0];
            r_s2_vld   <= r_s1_vld;
            r_s2_idx   <= r_s1_idx;
            r_s2_known <= r_sig_rd[BW];
            if (issue) begin
                r_walk_i <= r_walk_i + 1'b1;
            end
            if (better) begin
                r_found    <= 1'b1;
                r_best_idx <= r_s2_idx;
                r_best_cnt <= walk_cnt;
            end

            if (o_out.valid && o_out.ready && !res_load) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        if (stored) begin
                            r_elem_cnt <= r_elem_cnt + 1'b1;
                        end
                        r_upd_addr <= i_head.item.byte_value;
                        r_upd_last <= i_head.item.is_last;
                        if (stored && i_head.item.fully_known) begin
                            r_state <= S_UPD;
                        end else if (i_head.item.is_last) begin
                            r_state <= S_WALK;
                        end
                    end
                end
                S_UPD: begin
                    r_hvalid[r_upd_addr] <= 1'b1;
                    r_state <= r_upd_last ? S_WALK : S_IDLE;
                end
                S_WALK: begin
                    if (walk_done) begin
                        r_state <= S_RES;
                    end
                end
                S_RES: begin
                    if (res_load) begin
                        r_out_valid <= 1'b1;
                        r_out_found <= r_found;
                        r_out_idx   <= r_found ? best_idx_ext[rbas_pkg::OUT_IDX_W-1:0] : '0;
                        r_out_cnt   <= r_found ? r_best_cnt : '0;
                        // clear histogram and signature for the next one
                        r_hvalid    <= '0;
                        r_elem_cnt  <= '0;
                        r_walk_i    <= '0;
                        r_found     <= 1'b0;
                        r_best_idx  <= '0;
                        r_best_cnt  <= rbas_pkg::HIST_CNT_MAX;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.found        = r_out_found;
    assign o_out.anchor_index = r_out_idx;
    assign o_out.anchor_count = r_out_cnt;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_elem_cnt <= CW'(rbas_pkg::MAX_SIG_LEN))
        else $error("element count past capacity");

    a_hist_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |=> (r_hvalid == '0) && (r_elem_cnt == '0))
        else $error("histogram not cleared after result");

    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_idx == '0) && (r_out_cnt == '0))
        else $error("not-found result carries nonzero fields");

    a_upd_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> $past(pop))
        else $error("histogram update without an element");

    a_walk_idle_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK || r_state == S_RES) |-> !o_pop)
        else $error("element taken during selection");

endmodule

[src/rarest_byte_anchor_select_top.sv]
// Channel   Dir  Payload                                   Handshake
// i_in      in   byte_value[7:0], fully_known, is_last     valid/ready
// o_out     out  found, anchor_index[5:0], anchor_count[7:0] valid/ready
//
// A stored fully known element reads the histogram when it is taken and writes the incremented
// count in the update state; a wildcard or an element past capacity is only taken. The last
// element adds a walk over the N stored elements, then a load of the result register.
// Reset is synchronous, active low, and clears the histogram at once through per-bin valid bits.
// A 4-word queue takes input during the walk; a waiting result stalls only the final load.
module rarest_byte_anchor_select_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rbas_in_if.sink     i_in,
    rbas_out_if.source  o_out
);

    rbas_pkg::t_q_head  head;
    logic               pop;

    rbas_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_pop   (pop),
        .o_head  (head)
    );

    rbas_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
